// ===== rtl/lrcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrcc_pkg: shared types and constants of the log record chain checker
// Field widths, per-word masks, record payload sizes and pipeline stage structs.
// ----------------------------------------------------------------------------
package lrcc_pkg;

  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned NUM_LANES = 4;

  // payload bytes carried by a first, a last and any other record
  localparam logic [15:0] FIRST_PAY = 16'd14;
  localparam logic [15:0] LAST_PAY  = 16'd24;
  localparam logic [15:0] OTHER_PAY = 16'd28;

  // x / 28 = (x >> 2) / 7; (y * 18725) >> 17 is exact for y below 43690
  localparam logic [14:0] RECIP_SEVEN = 15'd18725;
  localparam int unsigned RECIP_SHIFT = 17;

  // first record: words 0..3 and the checksum half of word 4 stay out of the seed
  localparam logic [NUM_WORDS-1:0][31:0] SEED_MASK = {
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  // halfwords 0..14 enter the header checksum; the top half of word 7 does not
  localparam logic [NUM_WORDS-1:0][31:0] HALF_MASK = {
    32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [NUM_LANES-1:0][31:0] lane_sum;
    logic [NUM_LANES-1:0][15:0] lane_hsum;
    logic [8:0]                 rec_index;
    logic [6:0]                 seq_num;
    logic                       is_first;
    logic                       is_last;
    logic [15:0]                capture_bits;
    logic [62:0]                time_stamp;
    logic [15:0]                byte_count;
    logic [15:0]                checksum;
    logic [15:0]                network_id;
  } stage_a_t;

  typedef struct packed {
    logic [31:0] total;
    logic [15:0] hsum;
    logic [11:0] record_count;
    logic [8:0]  rec_index;
    logic [6:0]  seq_num;
    logic        is_first;
    logic        is_last;
    logic [15:0] capture_bits;
    logic [62:0] time_stamp;
    logic [15:0] checksum;
    logic [15:0] network_id;
  } stage_b_t;

endpackage

// ===== rtl/lrcc_in_if.sv =====
// ----------------------------------------------------------------------------
// lrcc_in_if: record input channel
// Valid/ready channel carrying one 32-byte log record and its last flag.
// ----------------------------------------------------------------------------
interface lrcc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rec_dword0;
  logic [31:0] rec_dword1;
  logic [31:0] rec_dword2;
  logic [31:0] rec_dword3;
  logic [31:0] rec_dword4;
  logic [31:0] rec_dword5;
  logic [31:0] rec_dword6;
  logic [31:0] rec_dword7;
  logic        is_last;

  modport source (
    output valid, rec_dword0, rec_dword1, rec_dword2, rec_dword3,
           rec_dword4, rec_dword5, rec_dword6, rec_dword7, is_last,
    input  ready
  );

  modport sink (
    input  valid, rec_dword0, rec_dword1, rec_dword2, rec_dword3,
           rec_dword4, rec_dword5, rec_dword6, rec_dword7, is_last,
    output ready
  );
endinterface

// ===== rtl/lrcc_out_if.sv =====
// ----------------------------------------------------------------------------
// lrcc_out_if: result output channel
// Valid/ready channel carrying the decoded fields and check result of a record.
// ----------------------------------------------------------------------------
interface lrcc_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  rec_index;
  logic [6:0]  seq_num;
  logic        is_first;
  logic [11:0] record_count;
  logic [15:0] capture_bits;
  logic [62:0] time_stamp;
  logic        sum_failed;
  logic [15:0] network_id;
  logic [31:0] running_sum;

  modport source (
    output valid, rec_index, seq_num, is_first, record_count, capture_bits,
           time_stamp, sum_failed, network_id, running_sum,
    input  ready
  );

  modport sink (
    input  valid, rec_index, seq_num, is_first, record_count, capture_bits,
           time_stamp, sum_failed, network_id, running_sum,
    output ready
  );
endinterface

// ===== rtl/lrcc_lane.sv =====
// ----------------------------------------------------------------------------
// lrcc_lane: two-word summing lane
// Adds a pair of record words for the running sum and folds their halfwords
// into a 16-bit partial checksum.
// ----------------------------------------------------------------------------
module lrcc_lane
  import lrcc_pkg::*;
(
  input  logic [31:0] w_lo,
  input  logic [31:0] w_hi,
  input  logic [31:0] seed_mask_lo,
  input  logic [31:0] seed_mask_hi,
  input  logic [31:0] half_mask_lo,
  input  logic [31:0] half_mask_hi,
  input  logic        first,
  output logic [31:0] sum,
  output logic [15:0] hsum
);

  logic [31:0] add_lo;
  logic [31:0] add_hi;
  logic [31:0] h_lo;
  logic [31:0] h_hi;

  always_comb begin
    // a first record only seeds from its payload words
    add_lo = first ? (w_lo & seed_mask_lo) : w_lo;
    add_hi = first ? (w_hi & seed_mask_hi) : w_hi;
    sum    = add_lo + add_hi;
    h_lo   = w_lo & half_mask_lo;
    h_hi   = w_hi & half_mask_hi;
    hsum   = h_lo[15:0] + h_lo[31:16] + h_hi[15:0] + h_hi[31:16];
  end

endmodule

// ===== rtl/lrcc_merge.sv =====
// ----------------------------------------------------------------------------
// lrcc_merge: lane merge stage
// Reduces the lane partial sums, derives the record count from the byte
// count and registers the result with its side fields.
// ----------------------------------------------------------------------------
module lrcc_merge
  import lrcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     in_valid,
  input  stage_a_t in_stage,
  output logic     out_valid,
  output stage_b_t out_stage
);

  logic [31:0] total;
  logic [15:0] hsum;
  logic [15:0] rest;
  logic [16:0] rest_up;
  logic [14:0] quarter;
  logic [29:0] product;
  logic [11:0] count;

  always_comb begin
    total = 32'd0;
    hsum  = 16'd0;
    for (int i = 0; i < NUM_LANES; i++) begin
      total = total + in_stage.lane_sum[i];
      hsum  = hsum + in_stage.lane_hsum[i];
    end

    // ceil(rest / 28) as floor((rest + 27) / 28)
    rest    = in_stage.byte_count - (FIRST_PAY + LAST_PAY);
    rest_up = {1'b0, rest} + {1'b0, OTHER_PAY - 16'd1};
    quarter = rest_up[16:2];
    product = quarter * RECIP_SEVEN;

    if (in_stage.byte_count <= FIRST_PAY) begin
      count = 12'd1;
    end else if (in_stage.byte_count <= FIRST_PAY + LAST_PAY) begin
      count = 12'd2;
    end else begin
      count = product[RECIP_SHIFT+11:RECIP_SHIFT] + 12'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stage.total        <= total;
      out_stage.hsum         <= hsum;
      out_stage.record_count <= count;
      out_stage.rec_index    <= in_stage.rec_index;
      out_stage.seq_num      <= in_stage.seq_num;
      out_stage.is_first     <= in_stage.is_first;
      out_stage.is_last      <= in_stage.is_last;
      out_stage.capture_bits <= in_stage.capture_bits;
      out_stage.time_stamp   <= in_stage.time_stamp;
      out_stage.checksum     <= in_stage.checksum;
      out_stage.network_id   <= in_stage.network_id;
    end
  end

endmodule

// ===== rtl/log_record_chain_checker.sv =====
// An input transfer passes stage A, the merge stage and the output register.
// Throughput: one record per cycle when not stalled; the running-sum register
// closes its loop through one 32-bit add of the merged lane total.
// Stalls: a full stage holds while the one after it waits; input ready follows.
// Reset: synchronous, clears stage valids, the running sum and the kept count.
// ----------------------------------------------------------------------------
// log_record_chain_checker: log record chain checker
// Four summing lanes split each record, a merge stage reduces their sums and
// decodes the record count, and the final stage updates the chain state.
// ----------------------------------------------------------------------------
module log_record_chain_checker
  import lrcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lrcc_in_if.sink    rec,
  lrcc_out_if.source res
);

  logic [NUM_WORDS-1:0][31:0] words;
  logic [NUM_LANES-1:0][31:0] lane_sum;
  logic [NUM_LANES-1:0][15:0] lane_hsum;
  logic                       first_in;

  logic     a_valid;
  stage_a_t a_stage;
  logic     b_valid;
  stage_b_t b_stage;

  logic adv_a;
  logic adv_b;
  logic adv_c;

  logic [31:0] chain_sum;
  logic [31:0] chain_sum_next;
  logic [11:0] kept_count;
  logic [11:0] kept_count_next;
  logic        failed;

  assign words = {rec.rec_dword7, rec.rec_dword6, rec.rec_dword5, rec.rec_dword4,
                  rec.rec_dword3, rec.rec_dword2, rec.rec_dword1, rec.rec_dword0};
  assign first_in = (rec.rec_dword0[24:16] == 9'd0);

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lrcc_lane u_lane (
      .w_lo         (words[2*g]),
      .w_hi         (words[2*g+1]),
      .seed_mask_lo (SEED_MASK[2*g]),
      .seed_mask_hi (SEED_MASK[2*g+1]),
      .half_mask_lo (HALF_MASK[2*g]),
      .half_mask_hi (HALF_MASK[2*g+1]),
      .first        (first_in),
      .sum          (lane_sum[g]),
      .hsum         (lane_hsum[g])
    );
  end

  // advance a stage when it is empty or the one after it is moving
  assign adv_c     = ~res.valid | res.ready;
  assign adv_b     = ~b_valid | adv_c;
  assign adv_a     = ~a_valid | adv_b;
  assign rec.ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv_a) begin
      a_valid <= rec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_stage.lane_sum     <= lane_sum;
      a_stage.lane_hsum    <= lane_hsum;
      a_stage.rec_index    <= rec.rec_dword0[24:16];
      a_stage.seq_num      <= rec.rec_dword0[31:25];
      a_stage.is_first     <= first_in;
      a_stage.is_last      <= rec.is_last;
      a_stage.capture_bits <= rec.rec_dword1[15:0];
      a_stage.time_stamp   <= {rec.rec_dword3[30:0], rec.rec_dword2};
      a_stage.byte_count   <= rec.rec_dword1[31:16];
      a_stage.checksum     <= rec.rec_dword4[15:0];
      a_stage.network_id   <= rec.rec_dword7[15:0];
    end
  end

  lrcc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv_b),
    .in_valid  (a_valid),
    .in_stage  (a_stage),
    .out_valid (b_valid),
    .out_stage (b_stage)
  );

  always_comb begin
    if (b_stage.is_first) begin
      chain_sum_next  = b_stage.total;
      kept_count_next = b_stage.record_count;
      failed          = (b_stage.hsum != b_stage.checksum);
    end else begin
      chain_sum_next  = chain_sum + b_stage.total;
      kept_count_next = kept_count;
      failed          = b_stage.is_last & (chain_sum_next != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid  <= 1'b0;
      chain_sum  <= 32'd0;
      kept_count <= 12'd0;
    end else if (adv_c) begin
      res.valid <= b_valid;
      if (b_valid) begin
        chain_sum  <= chain_sum_next;
        kept_count <= kept_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      res.rec_index    <= b_stage.rec_index;
      res.seq_num      <= b_stage.seq_num;
      res.is_first     <= b_stage.is_first;
      res.record_count <= kept_count_next;
      res.capture_bits <= b_stage.is_first ? b_stage.capture_bits : 16'd0;
      res.time_stamp   <= b_stage.is_first ? b_stage.time_stamp : 63'd0;
      res.sum_failed   <= failed;
      res.network_id   <= (b_stage.is_first | b_stage.is_last) ? 16'd0
                                                               : b_stage.network_id;
      res.running_sum  <= chain_sum_next;
    end
  end

endmodule
